>>> rtl/nto_pkg.sv
package nto_pkg;

   // operation codes
   localparam logic OpBuild    = 1'b0;
   localparam logic OpResponse = 1'b1;

   localparam logic [29:0] NsPerSec   = 30'd1000000000;
   localparam logic [31:0] EpochShift = 32'd2208988800;

   // floor((2^64 - 1) / 1e9): quotient estimate is exact or one low
   localparam logic [34:0] RecipSec  = 35'(64'hFFFF_FFFF_FFFF_FFFF / 64'd1000000000);
   // floor(2^62 / 1e9): fraction estimate is exact or one low
   localparam logic [32:0] RecipFrac = 33'((64'd1 << 62) / 64'd1000000000);

   // register stages from the input register to the converter/offset outputs
   localparam int ConvLatency = 7;

endpackage

>>> rtl/nto_ns_to_ntp.sv
module nto_ns_to_ntp (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] ns,
   output logic [63:0] ntp
);

   logic [63:0] pll_in, pll_ff, phl_in, phl_ff;
   logic [34:0] plh_in, plh_ff, phh_in, phh_ff;
   logic [31:0] nlo1_ff, nlo2_ff, nlo3_ff;
   logic [64:0] mid_in, mid_ff;
   logic [63:0] pll2_ff;
   logic [34:0] phh2_ff;
   logic [99:0] total;
   logic [31:0] qa_in, qa3_ff, qa4_ff;
   logic [61:0] qd_prod;
   logic [31:0] rem4_in, rem4_ff;
   logic        over5;
   logic [31:0] rsub;
   logic [31:0] secs5_in, secs5_ff, secs6_ff, secs7_ff;
   logic [29:0] r5_in, r5_ff;
   logic [62:0] fp;
   logic [31:0] fa6_in, fa6_ff, fa7_ff;
   logic [61:0] fd_prod;
   logic [31:0] rem7_in, rem7_ff;
   logic [31:0] frac;

   // stage 1: partial products of ns * reciprocal
   assign pll_in = {32'd0, ns[31:0]} * {32'd0, nto_pkg::RecipSec[31:0]};
   assign phl_in = {32'd0, ns[63:32]} * {32'd0, nto_pkg::RecipSec[31:0]};
   assign plh_in = {3'd0, ns[31:0]} * {32'd0, nto_pkg::RecipSec[34:32]};
   assign phh_in = {3'd0, ns[63:32]} * {32'd0, nto_pkg::RecipSec[34:32]};

   // stage 2: cross terms
   assign mid_in = {30'd0, plh_ff} + {1'b0, phl_ff};

   // stage 3: quotient estimate, low 32 bits are all the seconds need
   assign total = {36'd0, pll2_ff} + {3'd0, mid_ff, 32'd0} + {1'b0, phh2_ff, 64'd0};
   assign qa_in = total[95:64];

   // stage 4: remainder mod 2^32 (exact, it stays below 2e9)
   assign qd_prod = {30'd0, qa3_ff} * {32'd0, nto_pkg::NsPerSec};
   assign rem4_in = nlo3_ff - qd_prod[31:0];

   // stage 5: correct the estimate, rebase seconds to 1900
   assign over5    = rem4_ff >= {2'd0, nto_pkg::NsPerSec};
   assign secs5_in = qa4_ff + nto_pkg::EpochShift + {31'd0, over5};
   assign rsub     = over5 ? rem4_ff - {2'd0, nto_pkg::NsPerSec} : rem4_ff;
   assign r5_in    = rsub[29:0];

   // stage 6: fraction estimate (r << 32) / 1e9
   assign fp     = {33'd0, r5_ff} * {30'd0, nto_pkg::RecipFrac};
   assign fa6_in = fp[61:30];

   // stage 7: fraction remainder, low word of (r << 32) is zero
   assign fd_prod = {30'd0, fa6_ff} * {32'd0, nto_pkg::NsPerSec};
   assign rem7_in = 32'd0 - fd_prod[31:0];

   assign frac = (rem7_ff >= {2'd0, nto_pkg::NsPerSec}) ? fa7_ff + 32'd1 : fa7_ff;
   assign ntp  = {secs7_ff, frac};

   always_ff @(posedge clock) begin
      if (enable) begin
         pll_ff   <= pll_in;
         phl_ff   <= phl_in;
         plh_ff   <= plh_in;
         phh_ff   <= phh_in;
         nlo1_ff  <= ns[31:0];
         mid_ff   <= mid_in;
         pll2_ff  <= pll_ff;
         phh2_ff  <= phh_ff;
         nlo2_ff  <= nlo1_ff;
         qa3_ff   <= qa_in;
         nlo3_ff  <= nlo2_ff;
         rem4_ff  <= rem4_in;
         qa4_ff   <= qa3_ff;
         secs5_ff <= secs5_in;
         r5_ff    <= r5_in;
         fa6_ff   <= fa6_in;
         secs6_ff <= secs5_ff;
         rem7_ff  <= rem7_in;
         fa7_ff   <= fa6_ff;
         secs7_ff <= secs6_ff;
      end
   end

endmodule

>>> rtl/nto_offset.sv
module nto_offset (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] origin,
   input  logic [63:0] peer_receive,
   input  logic [63:0] peer_transmit,
   input  logic [63:0] local_ns,
   output logic [63:0] offset
);

   logic [61:0] osec_prod;
   logic [63:0] oint_in, oint_ff;
   logic [61:0] ofrac_prod;
   logic [29:0] ofrac_in, ofrac_ff;
   logic [63:0] a_in, a1_ff, a2_ff;
   logic [63:0] t0_in, t0_ff;
   logic [63:0] sum_in, sum_ff;
   logic [63:0] hsum, half_in;
   logic [63:0] pad_ff [0:3];

   // stage 1: origin seconds back to the 1970 epoch; wraps for origins before 1970
   assign osec_prod  = {30'd0, origin[63:32]} * {32'd0, nto_pkg::NsPerSec};
   assign oint_in    = {2'd0, osec_prod} -
                       ({32'd0, nto_pkg::EpochShift} * {34'd0, nto_pkg::NsPerSec});
   assign ofrac_prod = {30'd0, origin[31:0]} * {32'd0, nto_pkg::NsPerSec};
   assign ofrac_in   = ofrac_prod[61:32];
   assign a_in       = peer_receive + peer_transmit - local_ns;

   // stage 2: t0
   assign t0_in = oint_ff + {34'd0, ofrac_ff};

   // stage 3: (t1 - t0) + (t2 - t3)
   assign sum_in = a2_ff - t0_ff;

   // stage 4: halve toward zero, add one first when negative
   assign hsum    = sum_ff + {63'd0, sum_ff[63]};
   assign half_in = {hsum[63], hsum[63:1]};

   // delay to line up with the converter output
   assign offset = pad_ff[3];

   always_ff @(posedge clock) begin
      if (enable) begin
         oint_ff   <= oint_in;
         ofrac_ff  <= ofrac_in;
         a1_ff     <= a_in;
         t0_ff     <= t0_in;
         a2_ff     <= a1_ff;
         sum_ff    <= sum_in;
         pad_ff[0] <= half_in;
         pad_ff[1] <= pad_ff[0];
         pad_ff[2] <= pad_ff[1];
         pad_ff[3] <= pad_ff[2];
      end
   end

endmodule

>>> rtl/ntp_timestamp_offset_unit.sv
// Throughput: one transaction per cycle; the whole pipeline stalls only while
// a finished result waits on rsp_ready. Depth is set by the ns-to-NTP converter
// (reciprocal multiply split in 32-bit partial products, then two corrections).
// Reset clears all stage valids, the output valid and the stored-reply flag.
module ntp_timestamp_offset_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [63:0]        req_local_time_ns,
   input  logic [63:0]        req_echoed_origin,
   input  logic [63:0]        req_peer_receive_ns,
   input  logic [63:0]        req_peer_transmit_ns,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_request_origin,
   output logic [63:0]        rsp_request_receive,
   output logic [63:0]        rsp_request_transmit,
   output logic signed [63:0] rsp_offset_ns,
   output logic               rsp_offset_valid
);

   typedef struct packed {
      logic        op;
      logic        arrival_nz;
      logic [63:0] peer_tx;
   } side_type;

   localparam int Last = nto_pkg::ConvLatency;

   logic        adv;
   logic        valid_ff [0:Last];
   side_type    side_ff  [1:Last];

   logic        in_op_ff;
   logic [63:0] in_ns_ff, in_origin_ff, in_rx_ff, in_tx_ff;

   logic [63:0] conv_ntp;
   logic [63:0] offset_val;

   logic        have_reply_ff;
   logic [63:0] stored_pt_ff, stored_ntp_ff;

   logic               rsp_valid_ff;
   logic [63:0]        rsp_origin_ff, rsp_origin_in;
   logic [63:0]        rsp_receive_ff, rsp_receive_in;
   logic [63:0]        rsp_transmit_ff, rsp_transmit_in;
   logic signed [63:0] rsp_offset_ff, rsp_offset_in;
   logic               rsp_offset_valid_ff, rsp_offset_valid_in;

   logic        last_is_rsp;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   nto_ns_to_ntp u_conv (
      .clock  (clock),
      .enable (adv),
      .ns     (in_ns_ff),
      .ntp    (conv_ntp)
   );

   nto_offset u_offset (
      .clock         (clock),
      .enable        (adv),
      .origin        (in_origin_ff),
      .peer_receive  (in_rx_ff),
      .peer_transmit (in_tx_ff),
      .local_ns      (in_ns_ff),
      .offset        (offset_val)
   );

   assign last_is_rsp = side_ff[Last].op == nto_pkg::OpResponse;

   always_comb begin
      if (last_is_rsp) begin
         rsp_origin_in       = '0;
         rsp_receive_in      = '0;
         rsp_transmit_in     = '0;
         rsp_offset_in       = $signed(offset_val);
         rsp_offset_valid_in = 1'b1;
      end else begin
         rsp_origin_in       = have_reply_ff ? stored_pt_ff : '0;
         rsp_receive_in      = have_reply_ff ? stored_ntp_ff : '0;
         rsp_transmit_in     = conv_ntp;
         rsp_offset_in       = '0;
         rsp_offset_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Last; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rsp_valid_ff  <= 1'b0;
         have_reply_ff <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i <= Last; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         rsp_valid_ff <= valid_ff[Last];
         if (valid_ff[Last] && last_is_rsp) begin
            // an arrival time of zero reads as no reply
            have_reply_ff <= side_ff[Last].arrival_nz;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_op_ff     <= req_operation;
         in_ns_ff     <= req_local_time_ns;
         in_origin_ff <= req_echoed_origin;
         in_rx_ff     <= req_peer_receive_ns;
         in_tx_ff     <= req_peer_transmit_ns;
         side_ff[1]   <= '{op: in_op_ff, arrival_nz: |in_ns_ff, peer_tx: in_tx_ff};
         for (int i = 2; i <= Last; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         if (valid_ff[Last]) begin
            rsp_origin_ff       <= rsp_origin_in;
            rsp_receive_ff      <= rsp_receive_in;
            rsp_transmit_ff     <= rsp_transmit_in;
            rsp_offset_ff       <= rsp_offset_in;
            rsp_offset_valid_ff <= rsp_offset_valid_in;
            if (last_is_rsp) begin
               stored_pt_ff  <= side_ff[Last].peer_tx;
               stored_ntp_ff <= conv_ntp;
            end
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_request_origin   = rsp_origin_ff;
   assign rsp_request_receive  = rsp_receive_ff;
   assign rsp_request_transmit = rsp_transmit_ff;
   assign rsp_offset_ns        = rsp_offset_ff;
   assign rsp_offset_valid     = rsp_offset_valid_ff;

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_offset_has_no_stamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_offset_valid |->
         rsp_request_origin == '0 && rsp_request_receive == '0 &&
         rsp_request_transmit == '0)
      else $error("offset result carries request stamps");

   a_no_reply_zero_stamps: assert property (@(posedge clock) disable iff (reset)
      adv && valid_ff[Last] && !last_is_rsp && !have_reply_ff |=>
         rsp_request_origin == '0 && rsp_request_receive == '0 && !rsp_offset_valid)
      else $error("request stamps nonzero with no stored reply");

endmodule
